### sv/cnrf_pkg.sv
// Shared types, constants and saturation helpers for the cubic Newton root finder.
`default_nettype none

package cnrf_pkg;

   localparam int Q_W       = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAX_ITER  = 64;
   localparam int TOL_W     = 16;
   localparam int ITER_W    = 7;
   localparam int STAT_W    = 2;
   localparam int STEP_W    = $clog2(MAX_ITER + 1);

   // divider: dividend is |f| scaled by 2^FRAC_BITS
   localparam int DVD_W = Q_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(DVD_W);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CUBIC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SQUARE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LINEAR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CONSTANT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 3'd4;

   localparam logic [STAT_W-1:0] STAT_CONVERGED  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO_DERIV = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LIMIT      = 2'd2;

   typedef logic signed [Q_W-1:0]   q_type;
   typedef logic signed [2*Q_W-1:0] wide_type;

   localparam wide_type Q_MAX_W = 64'sh0000_0000_7FFF_FFFF;
   localparam wide_type Q_MIN_W = 64'shFFFF_FFFF_8000_0000;

   function automatic wide_type widen(input q_type v);
      return wide_type'(v);
   endfunction

   // clamp a wide signed value to the Q16.16 range
   function automatic q_type sat_q(input wide_type v);
      q_type r;
      if (v > Q_MAX_W) begin
         r = q_type'(Q_MAX_W);
      end else if (v < Q_MIN_W) begin
         r = q_type'(Q_MIN_W);
      end else begin
         r = q_type'(v);
      end
      return r;
   endfunction

   function automatic q_type sat_add(input q_type a, input q_type b);
      return sat_q(widen(a) + widen(b));
   endfunction

endpackage

`default_nettype wire

### sv/cnrf_if.sv
// Handshake interfaces for the guess (request) and root (response) channels.
`default_nettype none

interface cnrf_req_if import cnrf_pkg::*; ();
   logic  valid;
   logic  ready;
   q_type initial_guess;

   modport source (output valid, output initial_guess, input ready);
   modport sink   (input valid, input initial_guess, output ready);
endinterface

interface cnrf_rsp_if import cnrf_pkg::*; ();
   logic              valid;
   logic              ready;
   q_type             root;
   logic [ITER_W-1:0] iterations;
   logic [STAT_W-1:0] status;

   modport source (output valid, output root, output iterations, output status,
                   input ready);
   modport sink   (input valid, input root, input iterations, input status,
                   output ready);
endinterface

`default_nettype wire

### sv/cubic_newton_root_finder_core.sv
// Top level: Newton-Raphson root of a cubic, sequencer around one multiplier and one divider.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+-------------------------
//   req     | in  | initial_guess (Q16.16)           | valid/ready
//   rsp     | out | root, iterations, status         | valid/ready
//   csr     | in  | csr_index, csr_wdata             | csr_we, no back-pressure
//
// One item at a time in the sequencer: req.ready is high only while idle. Each Newton
// step computes f and f' through the shared multiplier, waits on the bit-serial
// divide, then updates x; an item runs n steps, n <= 64. A finished result moves to
// an output register, so the next item can start while it waits; a second finished
// result waits in the sequencer until that register frees, which stalls further
// requests. Reset is synchronous and returns the sequencer to idle and the registers
// to their defaults (a=b=d=0, c=1.0, tolerance=1).
`default_nettype none

module cubic_newton_root_finder_core import cnrf_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   cnrf_req_if.sink             req,
   cnrf_rsp_if.source           rsp,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [Q_W-1:0]        csr_wdata
);

   // sequencer codes; M_ states issue a product, T_ states take it
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_M_XX   = 5'd1;
   localparam logic [4:0] ST_T_XX   = 5'd2;
   localparam logic [4:0] ST_M_X3   = 5'd3;
   localparam logic [4:0] ST_T_X3   = 5'd4;
   localparam logic [4:0] ST_M_AX3  = 5'd5;
   localparam logic [4:0] ST_T_AX3  = 5'd6;
   localparam logic [4:0] ST_M_BX2  = 5'd7;
   localparam logic [4:0] ST_T_BX2  = 5'd8;
   localparam logic [4:0] ST_M_CX   = 5'd9;
   localparam logic [4:0] ST_T_CX   = 5'd10;
   localparam logic [4:0] ST_F_SUM  = 5'd11;
   localparam logic [4:0] ST_F_CHK  = 5'd12;
   localparam logic [4:0] ST_M_AX2  = 5'd13;
   localparam logic [4:0] ST_T_AX2  = 5'd14;
   localparam logic [4:0] ST_M_BX   = 5'd15;
   localparam logic [4:0] ST_T_BX   = 5'd16;
   localparam logic [4:0] ST_DF_SUM = 5'd17;
   localparam logic [4:0] ST_DF_CHK = 5'd18;
   localparam logic [4:0] ST_DIV    = 5'd19;
   localparam logic [4:0] ST_X_UPD  = 5'd20;
   localparam logic [4:0] ST_DONE   = 5'd21;

   // configuration
   q_type            coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [TOL_W-1:0] tol_ff;

   // datapath
   logic [4:0]        state_ff, state_in;
   q_type             x_ff, x_in;
   q_type             x2_ff, x2_in;
   q_type             x3_ff, x3_in;
   q_type             s_ff, s_in;
   q_type             f_ff, f_in;
   q_type             df_ff, df_in;
   q_type             q_ff, q_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [STAT_W-1:0] status_ff, status_in;

   // output register
   logic              out_valid_ff;
   q_type             out_root_ff;
   logic [ITER_W-1:0] out_iter_ff;
   logic [STAT_W-1:0] out_stat_ff;
   logic              out_load;

   q_type    mul_a, mul_b, mul_res;
   logic     div_start, div_done;
   q_type    div_quot;
   wide_type f_w, tol_w;
   logic     converged;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= q_type'(1 << FRAC_BITS);
         coef_d_ff <= '0;
         tol_ff    <= TOL_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_CUBIC:    coef_a_ff <= csr_wdata;
            CSR_COEF_SQUARE:   coef_b_ff <= csr_wdata;
            CSR_COEF_LINEAR:   coef_c_ff <= csr_wdata;
            CSR_COEF_CONSTANT: coef_d_ff <= csr_wdata;
            CSR_TOLERANCE:     tol_ff    <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_M_X3:  begin mul_a = x2_ff;     mul_b = x_ff;  end
         ST_M_AX3: begin mul_a = coef_a_ff; mul_b = x3_ff; end
         ST_M_BX2: begin mul_a = coef_b_ff; mul_b = x2_ff; end
         ST_M_CX:  begin mul_a = coef_c_ff; mul_b = x_ff;  end
         ST_M_AX2: begin mul_a = coef_a_ff; mul_b = x2_ff; end
         ST_M_BX:  begin mul_a = coef_b_ff; mul_b = x_ff;  end
         default:  begin mul_a = x_ff;      mul_b = x_ff;  end
      endcase
   end

   cnrf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   assign div_start = (state_ff == ST_DF_CHK) && (df_ff != '0);

   cnrf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (f_ff),
      .den   (df_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // |f| <= tol
   assign f_w       = widen(f_ff);
   assign tol_w     = {{(2*Q_W-TOL_W){1'b0}}, tol_ff};
   assign converged = (f_w <= tol_w) && (f_w >= -tol_w);

   // finished result moves out once the output register is free or being emptied
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || rsp.ready);

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      x3_in     = x3_ff;
      s_in      = s_ff;
      f_in      = f_ff;
      df_in     = df_ff;
      q_in      = q_ff;
      steps_in  = steps_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               x_in     = req.initial_guess;
               steps_in = '0;
               state_in = ST_M_XX;
            end
         end
         ST_M_XX:  state_in = ST_T_XX;
         ST_T_XX: begin
            x2_in    = mul_res;
            state_in = ST_M_X3;
         end
         ST_M_X3:  state_in = ST_T_X3;
         ST_T_X3: begin
            x3_in    = mul_res;
            state_in = ST_M_AX3;
         end
         ST_M_AX3: state_in = ST_T_AX3;
         ST_T_AX3: begin
            s_in     = mul_res;
            state_in = ST_M_BX2;
         end
         ST_M_BX2: state_in = ST_T_BX2;
         ST_T_BX2: begin
            s_in     = sat_add(s_ff, mul_res);
            state_in = ST_M_CX;
         end
         ST_M_CX:  state_in = ST_T_CX;
         ST_T_CX: begin
            s_in     = sat_add(s_ff, mul_res);
            state_in = ST_F_SUM;
         end
         ST_F_SUM: begin
            f_in     = sat_add(s_ff, coef_d_ff);
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            // convergence is checked before the step limit
            if (converged) begin
               status_in = STAT_CONVERGED;
               state_in  = ST_DONE;
            end else if (steps_ff >= STEP_W'(MAX_ITER)) begin
               status_in = STAT_LIMIT;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_M_AX2;
            end
         end
         ST_M_AX2: state_in = ST_T_AX2;
         ST_T_AX2: begin
            // 3*a*x^2
            s_in     = sat_q((widen(mul_res) <<< 1) + widen(mul_res));
            state_in = ST_M_BX;
         end
         ST_M_BX:  state_in = ST_T_BX;
         ST_T_BX: begin
            // + 2*b*x
            s_in     = sat_add(s_ff, sat_q(widen(mul_res) <<< 1));
            state_in = ST_DF_SUM;
         end
         ST_DF_SUM: begin
            df_in    = sat_add(s_ff, coef_c_ff);
            state_in = ST_DF_CHK;
         end
         ST_DF_CHK: begin
            if (df_ff == '0) begin
               status_in = STAT_ZERO_DERIV;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q_in     = div_quot;
               state_in = ST_X_UPD;
            end
         end
         ST_X_UPD: begin
            x_in     = sat_q(widen(x_ff) - widen(q_ff));
            steps_in = steps_ff + 1'b1;
            state_in = ST_M_XX;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      x3_ff     <= x3_in;
      s_ff      <= s_in;
      f_ff      <= f_in;
      df_ff     <= df_in;
      q_ff      <= q_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_root_ff <= x_ff;
         out_iter_ff <= ITER_W'(steps_ff);
         out_stat_ff <= status_ff;
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = out_valid_ff;
   assign rsp.root       = out_root_ff;
   assign rsp.iterations = out_iter_ff;
   assign rsp.status     = out_stat_ff;

   // step counter never passes the limit
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEP_W'(MAX_ITER))
      else $error("step count beyond limit");

   // once an item is taken, no other is taken until the sequencer is idle again
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second item accepted while busy");

   // a divider completion only arrives while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("unexpected divider completion");

   // limit status only with the full step count
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STAT_LIMIT) |-> (rsp.iterations == ITER_W'(MAX_ITER)))
      else $error("limit status with short step count");

   // a zero-derivative exit never happens without a zero derivative
   a_zero_deriv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == STAT_ZERO_DERIV) |-> (df_ff == '0))
      else $error("zero derivative status with nonzero derivative");

endmodule

`default_nettype wire

### sv/cnrf_mul.sv
// Shared fixed-point multiplier: registered product, floor shift, saturation.
`default_nettype none

module cnrf_mul import cnrf_pkg::*; (
   input  wire   clock,
   input  q_type op_a,
   input  q_type op_b,
   output q_type res
);

   wide_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // arithmetic shift rounds toward minus infinity
   assign res = sat_q(prod_ff >>> FRAC_BITS);

endmodule

`default_nettype wire

### sv/cnrf_div.sv
// Restoring divider, one quotient bit per cycle: sat((num << FRAC_BITS) / den).
`default_nettype none

module cnrf_div import cnrf_pkg::*; (
   input  wire   clock,
   input  wire   reset,
   input  wire   start,
   input  q_type num,
   input  q_type den,
   output logic  done,
   output q_type quot
);

   logic [Q_W-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [Q_W-1:0]    dvs_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff, done_ff, neg_ff;

   logic [Q_W-1:0] num_abs, den_abs;
   logic [Q_W:0]   shifted;
   logic [Q_W+1:0] diff;
   logic           take;
   wide_type       signed_q;

   assign num_abs = num[Q_W-1] ? (~num + 1'b1) : num;
   assign den_abs = den[Q_W-1] ? (~den + 1'b1) : den;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign take    = ~diff[Q_W+1];
   assign rem_in  = take ? diff[Q_W-1:0] : shifted[Q_W-1:0];
   assign quo_in  = {quo_ff[DVD_W-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= {num_abs, {FRAC_BITS{1'b0}}};
         dvs_ff <= den_abs;
         neg_ff <= num[Q_W-1] ^ den[Q_W-1];
         cnt_ff <= DCNT_W'(DVD_W - 1);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // truncation toward zero: divide magnitudes, then apply the sign
   assign signed_q = neg_ff ? -wide_type'(quo_ff) : wide_type'(quo_ff);
   assign quot     = sat_q(signed_q);
   assign done     = done_ff;

endmodule

`default_nettype wire

### sim/cubic_newton_root_finder_core_tb.sv
// Testbench for the cubic Newton root finder: directed table, random phases, own predictor.

module cubic_newton_root_finder_core_tb;
   import cnrf_pkg::*;

   // Run shape
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_AFTER   = 900;   // no idling on either side past this many random items
   localparam int HOLD_AT      = 150;   // results taken before the long receiver hold-off
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 100;
   // Watchdog bound: ~1100 items each at the slowest legal length plus idling, taken ~6x over.
   localparam int CYCLE_LIMIT  = 30_000_000;

   localparam longint Q_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_LO = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      q_type             root;
      logic [ITER_W-1:0] iterations;
      logic [STAT_W-1:0] status;
   } root_result_type;

   // One row of the directed table: a register write or a guess, the latter with an
   // optional hand-computed result.
   typedef struct packed {
      bit                   is_write;
      logic [CSR_IDX_W-1:0] index;
      logic [Q_W-1:0]       value;
      bit                   typed;
      root_result_type      known;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [Q_W-1:0]       csr_wdata;

   cnrf_req_if req_ch ();
   cnrf_rsp_if rsp_ch ();

   cubic_newton_root_finder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor's copy of the registers, at their reset values
   q_type            cfg_cubic    = '0;
   q_type            cfg_square   = '0;
   q_type            cfg_linear   = 32'sh0001_0000;
   q_type            cfg_constant = '0;
   logic [TOL_W-1:0] cfg_tol      = 16'd1;

   root_result_type pending_roots[$];   // expected results, oldest first
   plan_row_type    plan[$];
   root_result_type head;
   int              mismatches  = 0;
   int              roots_taken = 0;
   int              cycle_count = 0;
   bit              calm        = 1'b0;
   bit              held_off    = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_q(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // Q16.16 product: floor shift of the exact product, then clamp
   function automatic longint fx_mul(longint p, longint q);
      return clamp_q((p * q) >>> FRAC_BITS);
   endfunction

   function automatic longint poly_value(longint x);
      longint x2, x3, s;
      x2 = fx_mul(x, x);
      x3 = fx_mul(x2, x);
      s  = fx_mul(longint'(cfg_cubic), x3);
      s  = clamp_q(s + fx_mul(longint'(cfg_square), x2));
      s  = clamp_q(s + fx_mul(longint'(cfg_linear), x));
      return clamp_q(s + longint'(cfg_constant));
   endfunction

   function automatic longint poly_slope(longint x);
      longint x2, t2, t1;
      x2 = fx_mul(x, x);
      t2 = clamp_q(3 * fx_mul(longint'(cfg_cubic), x2));
      t1 = clamp_q(2 * fx_mul(longint'(cfg_square), x));
      return clamp_q(clamp_q(t2 + t1) + longint'(cfg_linear));
   endfunction

   function automatic root_result_type newton_root(q_type guess);
      root_result_type r;
      longint          x, f, df, tol;
      int              steps;
      bit              done;
      x     = longint'(guess);
      tol   = longint'(cfg_tol);
      steps = 0;
      done  = 1'b0;
      r.status = STAT_LIMIT;
      while (!done) begin
         f = poly_value(x);
         // convergence is tested before each step, so a root needs no step at all
         if (f <= tol && f >= -tol) begin
            r.status = STAT_CONVERGED;
            done = 1'b1;
         end else if (steps >= MAX_ITER) begin
            r.status = STAT_LIMIT;
            done = 1'b1;
         end else begin
            df = poly_slope(x);
            if (df == 0) begin
               r.status = STAT_ZERO_DERIV;
               done = 1'b1;
            end else begin
               // SV signed division truncates toward zero
               x = clamp_q(x - clamp_q((f <<< FRAC_BITS) / df));
               steps++;
            end
         end
      end
      r.root       = q_type'(x);
      r.iterations = steps[ITER_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- table builders

   function automatic void plan_write(logic [CSR_IDX_W-1:0] idx, logic [Q_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.value    = val;
      plan.push_back(row);
   endfunction

   function automatic void plan_guess(q_type g);
      plan_row_type row;
      row = '0;
      row.value = g;
      plan.push_back(row);
   endfunction

   function automatic void plan_known(q_type g, q_type root, int iters, logic [STAT_W-1:0] st);
      plan_row_type row;
      row = '0;
      row.value            = g;
      row.typed            = 1'b1;
      row.known.root       = root;
      row.known.iterations = iters[ITER_W-1:0];
      row.known.status     = st;
      plan.push_back(row);
   endfunction

   // ---------------------------------------------------------------- random helpers

   function automatic q_type rand_span(int unsigned half);
      return q_type'(int'($urandom_range(0, 2 * half)) - int'(half));
   endfunction

   function automatic q_type pick_guess(bit zero_bias);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (zero_bias && r < 25) return '0;
      if (r < 10) return rand_span(4);            // a few LSBs around zero
      if (r < 30) return q_type'($urandom);       // anywhere, drives saturation
      return rand_span(2097152);                  // within +/-32.0
   endfunction

   // ---------------------------------------------------------------- drivers

   // Drop valid and wait until the block has handed back everything it was given.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_roots.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [Q_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COEF_CUBIC:    cfg_cubic    = q_type'(val);
         CSR_COEF_SQUARE:   cfg_square   = q_type'(val);
         CSR_COEF_LINEAR:   cfg_linear   = q_type'(val);
         CSR_COEF_CONSTANT: cfg_constant = q_type'(val);
         CSR_TOLERANCE:     cfg_tol      = val[TOL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one guess until taken; valid is left high so back-to-back items need no gap.
   task automatic send_guess(q_type g, bit typed, root_result_type known);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.initial_guess <= g;
      do @(posedge clock); while (!req_ch.ready);
      pending_roots.push_back(typed ? known : newton_root(g));
   endtask

   // ---------------------------------------------------------------- clock, watchdog

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result side

   // Receiver: random stalls between open stretches, one long hold-off once some
   // results are in (the sender keeps offering meanwhile), none at the end.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && roots_taken >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // Compare each taken result against the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         roots_taken++;
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected item: expected none, got root %h iter %0d status %0d",
                     $time, rsp_ch.root, rsp_ch.iterations, rsp_ch.status);
            mismatches++;
         end else begin
            head = pending_roots.pop_front();
            if (rsp_ch.root !== head.root) begin
               $display("%0t: root: expected %h, got %h", $time, head.root, rsp_ch.root);
               mismatches++;
            end
            if (rsp_ch.iterations !== head.iterations) begin
               $display("%0t: iterations: expected %0d, got %0d",
                        $time, head.iterations, rsp_ch.iterations);
               mismatches++;
            end
            if (rsp_ch.status !== head.status) begin
               $display("%0t: status: expected %0d, got %0d", $time, head.status, rsp_ch.status);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int unsigned      random_sent;
      int unsigned      kind;
      int unsigned      count;
      bit               zero_bias;
      bit               noise;
      logic [Q_W-1:0]   a, b, c, d, tol_word;
      root_result_type  none;

      random_sent = 0;
      none        = '0;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.initial_guess <= '0;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Reset registers give f(x) = x with tolerance 1.
      plan_known(32'sh0000_0000, 32'sh0000_0000, 0, STAT_CONVERGED);   // already a root
      plan_known(32'sh0000_0001, 32'sh0000_0001, 0, STAT_CONVERGED);   // |f| equals tolerance
      plan_known(32'sh7FFF_FFFF, 32'sh0000_0000, 1, STAT_CONVERGED);   // largest guess
      plan_known(32'sh8000_0000, 32'sh0000_0000, 1, STAT_CONVERGED);   // smallest guess
      plan_known(32'shFFFF_FFFE, 32'sh0000_0000, 1, STAT_CONVERGED);
      // zero tolerance: one LSB off is not close enough
      plan_write(CSR_TOLERANCE, 32'd0);
      plan_known(32'sh0000_0001, 32'sh0000_0000, 1, STAT_CONVERGED);
      // widest tolerance: bound is inclusive
      plan_write(CSR_TOLERANCE, 32'd65535);
      plan_known(32'sh0000_FFFF, 32'sh0000_FFFF, 0, STAT_CONVERGED);
      plan_known(32'sh0001_0000, 32'sh0000_0000, 1, STAT_CONVERGED);
      // f = 1.0 everywhere: slope is zero before the first step
      plan_write(CSR_COEF_LINEAR, 32'h0000_0000);
      plan_write(CSR_COEF_CONSTANT, 32'h0001_0000);
      plan_known(32'sh1234_5678, 32'sh1234_5678, 0, STAT_ZERO_DERIV);
      // x^3 - 2x + 2: Newton bounces between 0 and 1 until the step limit
      plan_write(CSR_TOLERANCE, 32'd1);
      plan_write(CSR_COEF_CUBIC, 32'h0001_0000);
      plan_write(CSR_COEF_LINEAR, 32'hFFFE_0000);
      plan_write(CSR_COEF_CONSTANT, 32'h0002_0000);
      plan_known(32'sh0000_0000, 32'sh0000_0000, MAX_ITER, STAT_LIMIT);
      plan_known(32'sh0001_0000, 32'sh0001_0000, MAX_ITER, STAT_LIMIT);
      // x^2 - 4: flat at the origin, converges from 3.0
      plan_write(CSR_COEF_CUBIC, 32'h0000_0000);
      plan_write(CSR_COEF_SQUARE, 32'h0001_0000);
      plan_write(CSR_COEF_LINEAR, 32'h0000_0000);
      plan_write(CSR_COEF_CONSTANT, 32'hFFFC_0000);
      plan_known(32'sh0000_0000, 32'sh0000_0000, 0, STAT_ZERO_DERIV);
      plan_guess(32'sh0003_0000);
      // extreme coefficients, everything saturates
      plan_write(CSR_COEF_CUBIC, 32'h7FFF_FFFF);
      plan_write(CSR_COEF_SQUARE, 32'h8000_0000);
      plan_write(CSR_COEF_LINEAR, 32'h7FFF_FFFF);
      plan_write(CSR_COEF_CONSTANT, 32'h8000_0000);
      plan_guess(32'sh7FFF_FFFF);
      plan_guess(32'sh8000_0000);
      plan_guess(32'sh0001_0000);
      plan_guess(32'sh0000_0000);
      plan_write(CSR_COEF_CUBIC, 32'h8000_0000);
      plan_write(CSR_COEF_SQUARE, 32'h7FFF_FFFF);
      plan_write(CSR_COEF_LINEAR, 32'h8000_0000);
      plan_write(CSR_COEF_CONSTANT, 32'h7FFF_FFFF);
      plan_guess(32'shFFFF_0000);
      plan_guess(32'sh4000_0000);

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            settle();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            send_guess(q_type'(plan[i].value), plan[i].typed, plan[i].known);
         end
      end

      // Random phases: a fresh polynomial per phase, written while the block is idle.
      // Mostly small well-behaved cubics so Newton gets somewhere; some quadratics that
      // go flat at the origin; a few phases of raw noise.
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         kind      = $urandom_range(0, 99);
         zero_bias = 1'b0;
         noise     = 1'b0;
         a         = rand_span(262144);        // +/-4.0
         b         = rand_span(1048576);       // +/-16.0
         c         = rand_span(1048576);
         d         = rand_span(1048576);
         tol_word  = $urandom_range(16, 4096);
         if (kind < 10) begin
            a = '0;
         end else if (kind < 25) begin
            // b*x^2 + d with opposite signs: two real roots, slope zero at x = 0
            a = '0;
            c = '0;
            if (b[Q_W-1] == d[Q_W-1]) d = -d;
            zero_bias = 1'b1;
         end else if (kind < 33) begin
            tol_word = $urandom_range(0, 65535);
         end else if (kind >= 92) begin
            noise    = 1'b1;
            a        = $urandom;
            b        = $urandom;
            c        = $urandom;
            d        = $urandom;
            tol_word = $urandom;                // upper bits must be ignored
         end
         write_reg(CSR_COEF_CUBIC, a);
         write_reg(CSR_COEF_SQUARE, b);
         write_reg(CSR_COEF_LINEAR, c);
         write_reg(CSR_COEF_CONSTANT, d);
         write_reg(CSR_TOLERANCE, tol_word);

         // noise phases mostly run to the step limit, so keep them short
         count = noise ? $urandom_range(3, 8) : $urandom_range(10, 40);
         repeat (count) begin
            if (random_sent < RANDOM_ITEMS) begin
               send_guess(pick_guess(zero_bias), 1'b0, none);
               random_sent++;
               calm = (random_sent >= CALM_AFTER);
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_roots.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
